// File: rtl/bmf_pkg.sv
// Package for the 5x5 box mean filter: sizes, register indexes, reciprocal
// constants and the structs passed between the filter's modules.
// Depends on nothing; every other file of the filter uses it.
`default_nettype none

package bmf_pkg;

	// Frame geometry.
	localparam int MAX_WIDTH  = 1024;
	localparam int MAX_HEIGHT = 4096;
	localparam int WIN        = 5;
	localparam int COL_W      = $clog2(MAX_WIDTH);
	localparam int ROW_W      = $clog2(MAX_HEIGHT);

	// Datapath widths.
	localparam int PIX_W  = 8;
	localparam int WORD_W = PIX_W * (WIN - 1);
	localparam int CSUM_W = 11;
	localparam int WSUM_W = 13;

	// Truncating divide by 25 as multiply by 5243 and shift right by 17.
	// Exact for every sum up to 25 * 255.
	localparam int PROD_W      = 26;
	localparam int RECIP_25    = 5243;
	localparam int RECIP_SHIFT = 17;

	// Configuration registers.
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 13;
	localparam int IMG_W_W    = 11;
	localparam int IMG_H_W    = 13;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;
	localparam logic [IMG_W_W-1:0]   WIDTH_RESET      = 11'd640;
	localparam logic [IMG_H_W-1:0]   HEIGHT_RESET     = 13'd512;

	// Output queue.
	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
	localparam int FIFO_CW    = FIFO_AW + 1;

	// Per-pixel control travelling alongside the datapath.
	typedef struct packed {
		logic vld;
		logic win_vld;
		logic frm_end;
		logic first;
	} tag_t;

	// One result beat.
	typedef struct packed {
		logic             window_valid;
		logic [PIX_W-1:0] mean_value;
		logic             frame_end;
	} res_t;

endpackage

`default_nettype wire

// File: rtl/bmf_if.sv
// Channel interfaces of the box mean filter: pixel input, result output and
// configuration write. Depends on bmf_pkg for the payload widths.
`default_nettype none

interface bmf_pix_if;
	logic                       valid;
	logic                       ready;
	logic [bmf_pkg::PIX_W-1:0]  pixel_value;

	modport source (output valid, output pixel_value, input ready);
	modport sink (input valid, input pixel_value, output ready);
endinterface

interface bmf_res_if;
	logic                       valid;
	logic                       ready;
	logic                       window_valid;
	logic [bmf_pkg::PIX_W-1:0]  mean_value;
	logic                       frame_end;

	modport source (output valid, output window_valid, output mean_value,
		output frame_end, input ready);
	modport sink (input valid, input window_valid, input mean_value,
		input frame_end, output ready);
endinterface

interface bmf_cfg_if;
	logic                            valid;
	logic                            ready;
	logic [bmf_pkg::CFG_IDX_W-1:0]   index;
	logic [bmf_pkg::CFG_DATA_W-1:0]  data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// File: rtl/bmf_col_store.sv
// Column line store: one synchronous memory holding the last four pixels of
// every column, read-modify-written once per pixel. Depends on bmf_pkg.
`default_nettype none

module bmf_col_store (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       acc,
	input  logic [bmf_pkg::COL_W-1:0]  col,
	input  logic [bmf_pkg::PIX_W-1:0]  pixel,
	output logic                       busy,
	output logic [bmf_pkg::CSUM_W-1:0] full_sum
);
	import bmf_pkg::*;

	// Newest pixel in the low byte, oldest in the high byte. The running
	// column sum is the sum of these four bytes, so it is not stored apart.
	logic [WORD_W-1:0] mem [MAX_WIDTH];
	logic [WORD_W-1:0] rd_q;
	logic [WORD_W-1:0] wd_q;
	logic [WORD_W-1:0] word;
	logic [WORD_W-1:0] new_word;

	logic              v_s1;
	logic              fwd_s1;
	logic [COL_W-1:0]  col_s1;
	logic [PIX_W-1:0]  pix_s1;

	logic              clr_q;
	logic [COL_W-1:0]  clr_cnt_q;

	logic              we;
	logic [COL_W-1:0]  wa;
	logic [WORD_W-1:0] wd;

	// Pick the stored word, or the word written back on the previous beat
	// when that beat hit the same column in the same cycle as this read.
	always_comb begin
		word     = fwd_s1 ? wd_q : rd_q;
		new_word = {word[WORD_W-PIX_W-1:0], pix_s1};
		full_sum = CSUM_W'(pix_s1);
		for (int i = 0; i < WIN - 1; i++) begin
			full_sum = full_sum + CSUM_W'(word[i*PIX_W +: PIX_W]);
		end
	end

	// Write port: clearing sweep after reset, else the write-back.
	always_comb begin
		we = clr_q | v_s1;
		wa = clr_q ? clr_cnt_q : col_s1;
		wd = clr_q ? '0 : new_word;
	end

	// Memory with registered read data.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[wa] <= wd;
		end
		if (acc) begin
			rd_q <= mem[col];
		end
	end

	// Stage one payload and forwarding select.
	always_ff @(posedge clk) begin
		wd_q <= new_word;
		if (acc) begin
			col_s1 <= col;
			pix_s1 <= pixel;
			fwd_s1 <= v_s1 && (col_s1 == col);
		end
	end

	// Stage valid and the clearing sweep.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1      <= 1'b0;
			clr_q     <= 1'b1;
			clr_cnt_q <= '0;
		end else begin
			v_s1 <= acc;
			if (clr_q) begin
				clr_cnt_q <= clr_cnt_q + 1'b1;
				if (clr_cnt_q == COL_W'(MAX_WIDTH - 1)) begin
					clr_q <= 1'b0;
				end
			end
		end
	end

	assign busy = clr_q;

`ifndef SYNTHESIS
	// No pixel may enter while the sweep owns the write port.
	a_no_acc_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		acc |-> !clr_q)
		else $error("pixel accepted during clearing sweep");

	// A write-back is never dropped in favour of the sweep.
	a_no_wb_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 |-> !clr_q)
		else $error("write-back collides with clearing sweep");
`endif

endmodule

`default_nettype wire

// File: rtl/bmf_win_sum.sv
// Horizontal window: the last five full column sums of the row, the running
// window sum and the divide by 25. Depends on bmf_pkg.
`default_nettype none

module bmf_win_sum (
	input  logic                       clk,
	input  logic                       arst_n,
	input  bmf_pkg::tag_t              tag_i,
	input  logic [bmf_pkg::CSUM_W-1:0] full_sum,
	output bmf_pkg::tag_t              tag_o,
	output bmf_pkg::res_t              res_o
);
	import bmf_pkg::*;

	logic [CSUM_W-1:0] recent_q [WIN];
	logic [WSUM_W-1:0] ws_q;
	logic [WSUM_W-1:0] ws_base;
	logic [WSUM_W-1:0] ws_old;
	logic [WSUM_W-1:0] ws_new;
	logic [WSUM_W-1:0] ws_s2;
	tag_t              tag_s2;
	logic [PROD_W-1:0] prod;

	// At the first column the horizontal history counts as empty.
	always_comb begin
		ws_base = tag_i.first ? '0 : ws_q;
		ws_old  = tag_i.first ? '0 : WSUM_W'(recent_q[WIN-1]);
		ws_new  = ws_base + WSUM_W'(full_sum) - ws_old;
	end

	// Shift the column sums and keep the window sum.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < WIN; i++) begin
				recent_q[i] <= '0;
			end
			ws_q   <= '0;
			tag_s2 <= '0;
		end else begin
			tag_s2 <= tag_i;
			if (tag_i.vld) begin
				recent_q[0] <= full_sum;
				for (int i = 1; i < WIN; i++) begin
					recent_q[i] <= tag_i.first ? '0 : recent_q[i-1];
				end
				ws_q <= ws_new;
			end
		end
	end

	always_ff @(posedge clk) begin
		ws_s2 <= ws_new;
	end

	// Divide by 25 through the reciprocal; the output queue registers it.
	always_comb begin
		prod               = PROD_W'(ws_s2) * PROD_W'(RECIP_25);
		res_o.window_valid = tag_s2.win_vld;
		res_o.mean_value   = tag_s2.win_vld ? prod[RECIP_SHIFT +: PIX_W] : '0;
		res_o.frame_end    = tag_s2.frm_end;
	end

	assign tag_o = tag_s2;

endmodule

`default_nettype wire

// File: rtl/bmf_out_fifo.sv
// Output queue of the box mean filter: four result beats, drives the result
// channel. Depends on bmf_pkg and bmf_res_if.
`default_nettype none

module bmf_out_fifo (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        push,
	input  bmf_pkg::res_t               push_data,
	output logic [bmf_pkg::FIFO_CW-1:0] occ,
	bmf_res_if.source                   res_o
);
	import bmf_pkg::*;

	res_t               mem_q [FIFO_DEPTH];
	logic [FIFO_AW-1:0] wr_ptr_q;
	logic [FIFO_AW-1:0] rd_ptr_q;
	logic [FIFO_CW-1:0] cnt_q;
	logic               pop;
	res_t               head;

	assign head               = mem_q[rd_ptr_q];
	assign res_o.valid        = (cnt_q != '0);
	assign res_o.window_valid = head.window_valid;
	assign res_o.mean_value   = head.mean_value;
	assign res_o.frame_end    = head.frame_end;
	assign pop                = res_o.valid & res_o.ready;
	assign occ                = cnt_q;

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

`ifndef SYNTHESIS
	// The input credit check must keep the queue from overflowing.
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (cnt_q != FIFO_CW'(FIFO_DEPTH)) || pop)
		else $error("result queue overflow");
`endif

endmodule

`default_nettype wire

// File: rtl/box_mean_filter_5x5_top.sv
// Top level of the 5x5 box mean filter: configuration registers, frame
// counters, input credit and the chain col_store -> win_sum -> out_fifo.
// Depends on bmf_pkg, the bmf interfaces and the three submodules.
//
//   channel  dir  beat                                    ready
//   pix      in   pixel_value                             credit free, sweep done
//   res      out  window_valid, mean_value, frame_end     from sink
//   cfg      in   index, data                             always high
//
// One pixel per cycle sustained while res is ready and the sweep is done;
// a result is offered on res once its pixel has passed the line store read
// (registered at the accepting edge), the window sum register and the divide
// into the queue. After reset a sweep zeroes the line store with pix.ready low.
// Stalls on res fill the four-beat queue; pix.ready drops when in-flight
// pixels plus queued beats reach four, so no beat is ever dropped.
`default_nettype none

module box_mean_filter_5x5_top (
	input  logic       clk,
	input  logic       arst_n,
	bmf_pix_if.sink    pix,
	bmf_res_if.source  res,
	bmf_cfg_if.sink    cfg
);
	import bmf_pkg::*;

	logic [IMG_W_W-1:0]  width_q;
	logic [IMG_H_W-1:0]  height_q;
	logic [COL_W-1:0]    col_q;
	logic [ROW_W-1:0]    row_q;
	logic [IMG_W_W-1:0]  w_eff;
	logic [IMG_H_W-1:0]  h_eff;
	logic [IMG_W_W-1:0]  col_nx;
	logic [IMG_H_W-1:0]  row_nx;
	logic                acc;
	logic                busy;
	logic [FIFO_CW-1:0]  occ;
	logic [FIFO_CW-1:0]  in_flight;
	logic [CSUM_W-1:0]   full_sum;
	tag_t                tag_s1;
	tag_t                tag_s2;
	res_t                res_s2;

	// Configuration writes are always taken.
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WIDTH_RESET;
			height_q <= HEIGHT_RESET;
		end else if (cfg.valid) begin
			if (cfg.index == REG_IMAGE_WIDTH) begin
				width_q <= cfg.data[IMG_W_W-1:0];
			end else if (cfg.index == REG_IMAGE_HEIGHT) begin
				height_q <= cfg.data[IMG_H_W-1:0];
			end
		end
	end

	// Effective frame size, clamped to what the store and counters hold.
	always_comb begin
		if (width_q == '0) begin
			w_eff = IMG_W_W'(1);
		end else if (width_q > IMG_W_W'(MAX_WIDTH)) begin
			w_eff = IMG_W_W'(MAX_WIDTH);
		end else begin
			w_eff = width_q;
		end
		if (height_q == '0) begin
			h_eff = IMG_H_W'(1);
		end else if (height_q > IMG_H_W'(MAX_HEIGHT)) begin
			h_eff = IMG_H_W'(MAX_HEIGHT);
		end else begin
			h_eff = height_q;
		end
		col_nx = IMG_W_W'(col_q) + 1'b1;
		row_nx = IMG_H_W'(row_q) + 1'b1;
	end

	// Input credit: beats in flight plus queued beats stay within the queue.
	assign in_flight = occ + FIFO_CW'(tag_s1.vld) + FIFO_CW'(tag_s2.vld);
	assign pix.ready = !busy && (in_flight < FIFO_CW'(FIFO_DEPTH));
	assign acc       = pix.valid & pix.ready;

	// Frame position and the per-pixel tag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q  <= '0;
			row_q  <= '0;
			tag_s1 <= '0;
		end else begin
			tag_s1.vld <= acc;
			if (acc) begin
				tag_s1.win_vld <= (row_q >= ROW_W'(WIN - 1)) && (col_q >= COL_W'(WIN - 1));
				tag_s1.frm_end <= (col_nx == w_eff) && (row_nx == h_eff);
				tag_s1.first   <= (col_q == '0);
				if (col_nx >= w_eff) begin
					col_q <= '0;
					if (row_nx >= h_eff) begin
						row_q <= '0;
					end else begin
						row_q <= row_nx[ROW_W-1:0];
					end
				end else begin
					col_q <= col_nx[COL_W-1:0];
				end
			end
		end
	end

	bmf_col_store u_col_store (
		.clk      (clk),
		.arst_n   (arst_n),
		.acc      (acc),
		.col      (col_q),
		.pixel    (pix.pixel_value),
		.busy     (busy),
		.full_sum (full_sum)
	);

	bmf_win_sum u_win_sum (
		.clk      (clk),
		.arst_n   (arst_n),
		.tag_i    (tag_s1),
		.full_sum (full_sum),
		.tag_o    (tag_s2),
		.res_o    (res_s2)
	);

	bmf_out_fifo u_out_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (tag_s2.vld),
		.push_data (res_s2),
		.occ       (occ),
		.res_o     (res)
	);

`ifndef SYNTHESIS
	// Queued plus in-flight beats never exceed the queue depth.
	a_credit: assert property (@(posedge clk) disable iff (!arst_n)
		in_flight <= FIFO_CW'(FIFO_DEPTH))
		else $error("input credit exceeded");

	// The column counter stays inside the line store.
	a_col_range: assert property (@(posedge clk) disable iff (!arst_n)
		acc |=> (IMG_W_W'(col_q) < IMG_W_W'(MAX_WIDTH)))
		else $error("column counter out of range");
`endif

endmodule

`default_nettype wire
